### design/vector_extra_lane_unit_top_macros.svh
// assertion helpers for the extra lane unit
`ifndef VECTOR_EXTRA_LANE_UNIT_TOP_MACROS_SVH
`define VECTOR_EXTRA_LANE_UNIT_TOP_MACROS_SVH

// property that must hold in the cycle after the trigger
`define VELU_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

// property that must hold at the same edge as the trigger
`define VELU_SAME(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

`endif

### design/velu_pkg.sv
package velu_pkg;

   localparam logic [31:0] EXP_MASK   = 32'h7F80_0000;
   localparam logic [31:0] MAN_MASK   = 32'h007F_FFFF;
   localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
   localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
   localparam logic [7:0]  BIAS       = 8'd127;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NONE  = 2'd1;
   localparam logic [1:0] ST_OTHER = 2'd2;

   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LL     = 5'd1;
   localparam logic [4:0] OP_SC     = 5'd2;
   localparam logic [4:0] OP_LVLQ   = 5'd3;
   localparam logic [4:0] OP_LVRQ   = 5'd4;
   localparam logic [4:0] OP_SVLQ   = 5'd5;
   localparam logic [4:0] OP_SVRQ   = 5'd6;
   localparam logic [4:0] OP_VSBN   = 5'd7;
   localparam logic [4:0] OP_VDET   = 5'd8;
   localparam logic [4:0] OP_VWBN   = 5'd9;
   localparam logic [4:0] OP_VRNDS  = 5'd10;
   localparam logic [4:0] OP_VSBZ   = 5'd11;
   localparam logic [4:0] OP_VLGB   = 5'd12;
   localparam logic [4:0] OP_VI2C   = 5'd13;
   localparam logic [4:0] OP_VI2US  = 5'd14;
   localparam logic [4:0] OP_VSRT1  = 5'd15;
   localparam logic [4:0] OP_VSRT2  = 5'd16;
   localparam logic [4:0] OP_VSRT3  = 5'd17;
   localparam logic [4:0] OP_VSRT4  = 5'd18;
   localparam logic [4:0] OP_VBFY2  = 5'd19;
   localparam logic [4:0] OP_VMFVC  = 5'd20;
   localparam logic [4:0] OP_VMTVC  = 5'd21;
   localparam logic [4:0] OP_VT4444 = 5'd22;
   localparam logic [4:0] OP_VT5551 = 5'd23;

   typedef logic [31:0] lane_type [4];

   function automatic logic [4:0] map_op(input logic [31:0] w);
      logic [5:0] major;
      logic [4:0] grp;
      logic [4:0] sub;
      logic [4:0] r;
      major = w[31:26];
      grp   = w[25:21];
      sub   = w[20:16];
      r     = OP_NONE;
      case (major)
         6'h30: r = OP_LL;
         6'h38: r = OP_SC;
         6'h35: r = w[1] ? OP_LVRQ : OP_LVLQ;
         6'h3D: r = w[1] ? OP_SVRQ : OP_SVLQ;
         6'h18: r = (w[25:23] == 3'd2) ? OP_VSBN : OP_NONE;
         6'h19: r = (w[25:23] == 3'd6) ? OP_VDET : OP_NONE;
         6'h34: begin
            if (grp >= 5'd24) begin
               r = OP_VWBN;
            end else if (grp == 5'd1) begin
               case (sub)
                  5'd0:    r = OP_VRNDS;
                  5'd22:   r = OP_VSBZ;
                  5'd23:   r = OP_VLGB;
                  5'd29:   r = OP_VI2C;
                  5'd30:   r = OP_VI2US;
                  default: r = OP_NONE;
               endcase
            end else if (grp == 5'd2) begin
               case (sub)
                  5'd0:    r = OP_VSRT1;
                  5'd1:    r = OP_VSRT2;
                  5'd3:    r = OP_VBFY2;
                  5'd8:    r = OP_VSRT3;
                  5'd9:    r = OP_VSRT4;
                  5'd16:   r = OP_VMFVC;
                  5'd17:   r = OP_VMTVC;
                  5'd25:   r = OP_VT4444;
                  5'd26:   r = OP_VT5551;
                  default: r = OP_NONE;
               endcase
            end
         end
         default: r = OP_NONE;
      endcase
      return r;
   endfunction

   function automatic logic is_nan(input logic [31:0] v);
      return v[30:0] > EXP_MASK[30:0];
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] v);
      return v[31] ? ~v : (v | SIGN_BIT);
   endfunction

   function automatic logic [15:0] shrink_colour(input logic [31:0] c, input logic four);
      if (four) begin
         return {c[31:28], c[23:20], c[15:12], c[7:4]};
      end
      return {c[31], c[23:19], c[15:11], c[7:3]};
   endfunction

   function automatic logic [15:0] clamp_half(input logic [31:0] v);
      return v[31] ? 16'd0 : v[30:15];
   endfunction

   function automatic logic [31:0] small_int_bits(input logic neg, input logic [7:0] mag);
      logic [2:0]  top;
      logic [31:0] m;
      top = 3'd0;
      for (int b = 1; b < 8; b++) begin
         if (mag[b]) top = 3'(b);
      end
      m = {24'd0, mag} << (5'd23 - {2'd0, top});
      if (mag == 8'd0) return 32'd0;
      return {neg, BIAS + {5'd0, top}, m[22:0]};
   endfunction

endpackage

### design/vector_extra_lane_unit_top.sv
// items move through the stages in order; a stalled output holds the flow
// throughput: one item per cycle; stages: decode/compare, lane compute, output
// each stage advances when the one after it is empty or moving
// reset: synchronous, active high; clears stage valid bits only
`include "vector_extra_lane_unit_top_macros.svh"

module vector_extra_lane_unit_top
   import velu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_src_x,
   input  logic [31:0] req_src_y,
   input  logic [31:0] req_src_z,
   input  logic [31:0] req_src_w,
   input  logic [31:0] req_tgt_x,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_which_op,
   output logic [6:0]  rsp_dest_reg,
   output logic [2:0]  rsp_result_count,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [31:0] rsp_out_w
);

   // stage advance
   logic v1_ff, v2_ff, v3_ff;
   logic go1, go2, go3;
   assign go3 = !v3_ff || !rsp_stall;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign req_stall = !go1;

   // stage 1: decode, mask lanes, sort compares
   logic [4:0]  op1_ff;
   logic [31:0] w1_ff, t1_ff;
   logic [2:0]  len1_ff;
   lane_type    s1_ff;
   logic        lt01_ff, lt03_ff, lt12_ff, lt23_ff;
   logic [2:0]  len_in;
   lane_type    s_in;

   always_comb begin
      len_in = {1'b0, req_instr_word[15], req_instr_word[7]} + 3'd1;
      s_in[0] = req_src_x;
      s_in[1] = (len_in > 3'd1) ? req_src_y : 32'd0;
      s_in[2] = (len_in > 3'd2) ? req_src_z : 32'd0;
      s_in[3] = (len_in > 3'd3) ? req_src_w : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (go1) begin
         v1_ff <= req_valid;
      end
      if (go1) begin
         op1_ff  <= map_op(req_instr_word);
         w1_ff   <= req_instr_word;
         t1_ff   <= req_tgt_x;
         len1_ff <= len_in;
         s1_ff   <= s_in;
         lt01_ff <= order_key(s_in[0]) <= order_key(s_in[1]);
         lt03_ff <= order_key(s_in[0]) <= order_key(s_in[3]);
         lt12_ff <= order_key(s_in[1]) <= order_key(s_in[2]);
         lt23_ff <= order_key(s_in[2]) <= order_key(s_in[3]);
      end
   end

   // stage 2: lane compute
   logic [1:0]  st_in;
   logic [2:0]  cnt_in;
   lane_type    d_in;
   logic [31:0] mn01, mx01, mn03, mx03, mn12, mx12, mn23, mx23;
   logic [7:0]  old, e;
   logic [31:0] m;
   logic [15:0] lo0, hi0, lo1, hi1;
   logic        four;

   function automatic logic [31:0] pick(input logic [31:0] a, input logic [31:0] b,
                                        input logic a_first);
      if (is_nan(a)) return b;
      if (is_nan(b)) return a;
      return a_first ? a : b;
   endfunction

   always_comb begin
      // max uses >=, which keeps a when the keys are equal
      mn01 = pick(s1_ff[0], s1_ff[1], lt01_ff);
      mx01 = pick(s1_ff[0], s1_ff[1], !lt01_ff || order_key(s1_ff[0]) == order_key(s1_ff[1]));
      mn03 = pick(s1_ff[0], s1_ff[3], lt03_ff);
      mx03 = pick(s1_ff[0], s1_ff[3], !lt03_ff || order_key(s1_ff[0]) == order_key(s1_ff[3]));
      mn12 = pick(s1_ff[1], s1_ff[2], lt12_ff);
      mx12 = pick(s1_ff[1], s1_ff[2], !lt12_ff || order_key(s1_ff[1]) == order_key(s1_ff[2]));
      mn23 = pick(s1_ff[2], s1_ff[3], lt23_ff);
      mx23 = pick(s1_ff[2], s1_ff[3], !lt23_ff || order_key(s1_ff[2]) == order_key(s1_ff[3]));
      old  = s1_ff[0][30:23];
      e    = 8'd0;
      m    = 32'd0;
      four = (op1_ff == OP_VT4444);
      lo0 = 16'd0; hi0 = 16'd0; lo1 = 16'd0; hi1 = 16'd0;
      st_in  = ST_DONE;
      cnt_in = 3'd0;
      for (int i = 0; i < 4; i++) d_in[i] = 32'd0;
      case (op1_ff)
         OP_NONE: st_in = ST_NONE;
         OP_VSBN, OP_VWBN, OP_VSBZ, OP_VLGB: begin
            d_in[1] = s1_ff[1];
            d_in[2] = s1_ff[2];
            d_in[3] = s1_ff[3];
            cnt_in  = len1_ff;
            if (op1_ff == OP_VSBN) begin
               e = BIAS + t1_ff[7:0];
               d_in[0] = (old != 8'd0 && old != 8'hFF) ?
                         ((s1_ff[0] & ~EXP_MASK) | {1'b0, e, 23'd0}) : s1_ff[0];
            end else if (op1_ff == OP_VWBN) begin
               e = w1_ff[23:16];
               d_in[0] = s1_ff[0] | {1'b0, e, 23'd0};
               if (old != 8'd0 && old != 8'hFF) begin
                  m = (s1_ff[0] & MAN_MASK) | HIDDEN_BIT;
                  if (e > old) m = m >> 4'(e - old);
                  else m = m << 4'(old - e);
                  d_in[0] = (s1_ff[0] & SIGN_BIT) | (m & MAN_MASK) | {1'b0, e, 23'd0};
               end
            end else if (op1_ff == OP_VSBZ) begin
               d_in[0] = (is_nan(s1_ff[0]) || old == 8'd0) ? s1_ff[0] :
                         ({1'b0, BIAS, 23'd0} | (s1_ff[0] & MAN_MASK));
            end else begin
               if (old == 8'hFF) d_in[0] = s1_ff[0];
               else if (old == 8'd0) d_in[0] = 32'hFF80_0000;
               else if (old >= BIAS) d_in[0] = small_int_bits(1'b0, old - BIAS);
               else d_in[0] = small_int_bits(1'b1, BIAS - old);
            end
         end
         OP_VI2C: begin
            d_in[0] = {s1_ff[3][31:24], s1_ff[2][31:24], s1_ff[1][31:24], s1_ff[0][31:24]};
            cnt_in  = 3'd1;
         end
         OP_VI2US, OP_VT4444, OP_VT5551: begin
            // odd lanes beyond the length are already zero, which packs as zero
            if (op1_ff == OP_VI2US) begin
               lo0 = clamp_half(s1_ff[0]); hi0 = clamp_half(s1_ff[1]);
               lo1 = clamp_half(s1_ff[2]); hi1 = clamp_half(s1_ff[3]);
            end else begin
               lo0 = shrink_colour(s1_ff[0], four); hi0 = shrink_colour(s1_ff[1], four);
               lo1 = shrink_colour(s1_ff[2], four); hi1 = shrink_colour(s1_ff[3], four);
            end
            cnt_in  = (len1_ff + 3'd1) >> 1;
            d_in[0] = {hi0, lo0};
            d_in[1] = {hi1, lo1};
         end
         OP_VSRT1: begin
            d_in[0] = mn01; d_in[1] = mx01; d_in[2] = mn23; d_in[3] = mx23;
            cnt_in = len1_ff;
         end
         OP_VSRT2: begin
            d_in[0] = mn03; d_in[1] = mn12; d_in[2] = mx12; d_in[3] = mx03;
            cnt_in = len1_ff;
         end
         OP_VSRT3: begin
            d_in[0] = mx01; d_in[1] = mn01; d_in[2] = mx23; d_in[3] = mn23;
            cnt_in = len1_ff;
         end
         OP_VSRT4: begin
            d_in[0] = mx03; d_in[1] = mx12; d_in[2] = mn12; d_in[3] = mn03;
            cnt_in = len1_ff;
         end
         default: st_in = ST_OTHER;
      endcase
   end

   logic [1:0] st2_ff;
   logic [4:0] op2_ff;
   logic [6:0] dr2_ff;
   logic [2:0] cnt2_ff;
   lane_type   d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (go2) begin
         v2_ff <= v1_ff;
      end
      if (go2) begin
         st2_ff  <= st_in;
         op2_ff  <= op1_ff;
         dr2_ff  <= (st_in == ST_NONE) ? 7'd0 : w1_ff[6:0];
         cnt2_ff <= cnt_in;
         d2_ff   <= d_in;
      end
   end

   // stage 3: zero unused lanes, output register
   lane_type d3_in;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         d3_in[i] = (3'(i) < cnt2_ff) ? d2_ff[i] : 32'd0;
      end
   end

   logic [1:0] st3_ff;
   logic [4:0] op3_ff;
   logic [6:0] dr3_ff;
   logic [2:0] cnt3_ff;
   lane_type   d3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (go3) begin
         v3_ff <= v2_ff;
      end
      if (go3) begin
         st3_ff  <= st2_ff;
         op3_ff  <= op2_ff;
         dr3_ff  <= dr2_ff;
         cnt3_ff <= cnt2_ff;
         d3_ff   <= d3_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_status       = st3_ff;
   assign rsp_which_op     = op3_ff;
   assign rsp_dest_reg     = dr3_ff;
   assign rsp_result_count = cnt3_ff;
   assign rsp_out_x        = d3_ff[0];
   assign rsp_out_y        = d3_ff[1];
   assign rsp_out_z        = d3_ff[2];
   assign rsp_out_w        = d3_ff[3];

   `VELU_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x), "stalled item lost")
   `VELU_SAME(a_none, rsp_valid && rsp_status == ST_NONE, rsp_which_op == OP_NONE && rsp_result_count == 3'd0, "bad none item")
   `VELU_SAME(a_cnt, rsp_valid && rsp_status != ST_DONE, rsp_out_x == 32'd0 && rsp_out_w == 32'd0, "lanes on uncomputed item")
   `VELU_SAME(a_w, rsp_valid && rsp_result_count < 3'd4, rsp_out_w == 32'd0, "unused lane set")

endmodule

### tb/tb_vector_extra_lane_unit_top.sv
`timescale 1ns / 100ps

module tb_vector_extra_lane_unit_top
   import velu_pkg::*;
();

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] src_x;
      logic [31:0] src_y;
      logic [31:0] src_z;
      logic [31:0] src_w;
      logic [31:0] tgt_x;
   } lane_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  which_op;
      logic [6:0]  dest_reg;
      logic [2:0]  result_count;
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic [31:0] out_w;
   } lane_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instr_word;
   logic [31:0] req_src_x;
   logic [31:0] req_src_y;
   logic [31:0] req_src_z;
   logic [31:0] req_src_w;
   logic [31:0] req_tgt_x;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_which_op;
   logic [6:0]  rsp_dest_reg;
   logic [2:0]  rsp_result_count;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic [31:0] rsp_out_w;

   lane_req_type pending_items[$];
   lane_rsp_type expected_lanes[$];
   int        fail_count;
   int        cycle_count;
   int        send_idle;
   int        recv_idle;
   bit        quiet_tail;
   bit        hold_send;

   vector_extra_lane_unit_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_instr_word(req_instr_word), .req_src_x(req_src_x), .req_src_y(req_src_y),
      .req_src_z(req_src_z), .req_src_w(req_src_w), .req_tgt_x(req_tgt_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_which_op(rsp_which_op), .rsp_dest_reg(rsp_dest_reg),
      .rsp_result_count(rsp_result_count), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_out_w(rsp_out_w)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------- prediction ----------------
   function automatic logic [4:0] decode_op(input logic [31:0] w);
      logic [4:0] grp;
      logic [4:0] sub;
      grp = w[25:21];
      sub = w[20:16];
      case (w[31:26])
         6'h30: return OP_LL;
         6'h38: return OP_SC;
         6'h35: return w[1] ? OP_LVRQ : OP_LVLQ;
         6'h3D: return w[1] ? OP_SVRQ : OP_SVLQ;
         6'h18: return (w[25:23] == 3'd2) ? OP_VSBN : OP_NONE;
         6'h19: return (w[25:23] == 3'd6) ? OP_VDET : OP_NONE;
         6'h34: begin
            if (grp >= 5'd24) return OP_VWBN;
            if (grp == 5'd1) begin
               case (sub)
                  5'd0:  return OP_VRNDS;
                  5'd22: return OP_VSBZ;
                  5'd23: return OP_VLGB;
                  5'd29: return OP_VI2C;
                  5'd30: return OP_VI2US;
                  default: return OP_NONE;
               endcase
            end
            if (grp == 5'd2) begin
               case (sub)
                  5'd0:  return OP_VSRT1;
                  5'd1:  return OP_VSRT2;
                  5'd3:  return OP_VBFY2;
                  5'd8:  return OP_VSRT3;
                  5'd9:  return OP_VSRT4;
                  5'd16: return OP_VMFVC;
                  5'd17: return OP_VMTVC;
                  5'd25: return OP_VT4444;
                  5'd26: return OP_VT5551;
                  default: return OP_NONE;
               endcase
            end
            return OP_NONE;
         end
         default: return OP_NONE;
      endcase
   endfunction

   function automatic bit nan_bits(input logic [31:0] v);
      return v[30:0] > 31'h7F80_0000;
   endfunction

   function automatic logic [31:0] sort_key(input logic [31:0] v);
      return v[31] ? ~v : {1'b1, v[30:0]};
   endfunction

   function automatic logic [31:0] sort_lo(input logic [31:0] a, input logic [31:0] b);
      if (nan_bits(a)) return b;
      if (nan_bits(b)) return a;
      return (sort_key(a) <= sort_key(b)) ? a : b;
   endfunction

   function automatic logic [31:0] sort_hi(input logic [31:0] a, input logic [31:0] b);
      if (nan_bits(a)) return b;
      if (nan_bits(b)) return a;
      return (sort_key(a) >= sort_key(b)) ? a : b;
   endfunction

   function automatic logic [15:0] squeeze_colour(input logic [31:0] c, input bit four);
      if (four) return {c[31:28], c[23:20], c[15:12], c[7:4]};
      return {c[31], c[23:19], c[15:11], c[7:3]};
   endfunction

   function automatic logic [31:0] int_to_float(input bit neg, input int mag);
      int top;
      logic [31:0] m;
      if (mag == 0) return 32'd0;
      top = 0;
      for (int t = mag; t > 1; t = t >> 1) top++;
      m = 32'(mag) << (23 - top);
      return {neg, 8'(127 + top), m[22:0]};
   endfunction

   function automatic lane_rsp_type predict_lanes(input lane_req_type r);
      lane_rsp_type p;
      logic [31:0] s[4];
      logic [31:0] d[4];
      logic [31:0] m;
      logic [7:0]  e;
      logic [7:0]  old;
      logic [15:0] lo;
      logic [15:0] hi;
      int          len;
      int          cnt;
      int          half;
      p = '0;
      p.which_op = decode_op(r.instr_word);
      len = {r.instr_word[15], r.instr_word[7]} + 1;
      s[0] = r.src_x;
      s[1] = (len > 1) ? r.src_y : 32'd0;
      s[2] = (len > 2) ? r.src_z : 32'd0;
      s[3] = (len > 3) ? r.src_w : 32'd0;
      d = '{default: 32'd0};
      cnt = 0;
      p.status = ST_DONE;
      old = s[0][30:23];
      case (p.which_op)
         OP_NONE: p.status = ST_NONE;
         OP_VSBN, OP_VWBN, OP_VSBZ, OP_VLGB: begin
            for (int i = 1; i < len; i++) d[i] = s[i];
            cnt = len;
            if (p.which_op == OP_VSBN) begin
               e = 8'(32'd127 + r.tgt_x);
               d[0] = (old != 8'h00 && old != 8'hFF) ? {s[0][31], e, s[0][22:0]} : s[0];
            end else if (p.which_op == OP_VWBN) begin
               e = r.instr_word[23:16];
               d[0] = s[0] | {1'b0, e, 23'd0};
               if (old != 8'h00 && old != 8'hFF) begin
                  m = {8'd0, 1'b1, s[0][22:0]};
                  if (e > old) m = m >> ((e - old) & 8'hF);
                  else m = m << ((old - e) & 8'hF);
                  d[0] = {s[0][31], e, m[22:0]};
               end
            end else if (p.which_op == OP_VSBZ) begin
               d[0] = (nan_bits(s[0]) || old == 8'h00) ? s[0] : {1'b0, 8'd127, s[0][22:0]};
            end else begin
               if (old == 8'hFF) d[0] = s[0];
               else if (old == 8'h00) d[0] = 32'hFF80_0000;
               else if (old >= 8'd127) d[0] = int_to_float(1'b0, old - 127);
               else d[0] = int_to_float(1'b1, 127 - old);
            end
         end
         OP_VI2C: begin
            for (int i = 0; i < len; i++) d[0][i*8 +: 8] = s[i][31:24];
            cnt = 1;
         end
         OP_VI2US, OP_VT4444, OP_VT5551: begin
            half = (len + 1) / 2;
            for (int i = 0; i < half; i++) begin
               if (p.which_op == OP_VI2US) begin
                  lo = s[2*i][31] ? 16'd0 : s[2*i][30:15];
                  hi = s[2*i+1][31] ? 16'd0 : s[2*i+1][30:15];
               end else begin
                  lo = squeeze_colour(s[2*i], p.which_op == OP_VT4444);
                  hi = squeeze_colour(s[2*i+1], p.which_op == OP_VT4444);
               end
               if (2*i + 1 >= len) hi = 16'd0;
               d[i] = {hi, lo};
            end
            cnt = half;
         end
         OP_VSRT1: begin
            d = '{sort_lo(s[0], s[1]), sort_hi(s[0], s[1]),
                  sort_lo(s[2], s[3]), sort_hi(s[2], s[3])};
            cnt = len;
         end
         OP_VSRT2: begin
            d = '{sort_lo(s[0], s[3]), sort_lo(s[1], s[2]),
                  sort_hi(s[1], s[2]), sort_hi(s[0], s[3])};
            cnt = len;
         end
         OP_VSRT3: begin
            d = '{sort_hi(s[0], s[1]), sort_lo(s[0], s[1]),
                  sort_hi(s[2], s[3]), sort_lo(s[2], s[3])};
            cnt = len;
         end
         OP_VSRT4: begin
            d = '{sort_hi(s[0], s[3]), sort_hi(s[1], s[2]),
                  sort_lo(s[1], s[2]), sort_lo(s[0], s[3])};
            cnt = len;
         end
         default: p.status = ST_OTHER;
      endcase
      for (int i = cnt; i < 4; i++) d[i] = 32'd0;
      p.dest_reg = (p.status == ST_NONE) ? 7'd0 : r.instr_word[6:0];
      p.result_count = 3'(cnt);
      p.out_x = d[0];
      p.out_y = d[1];
      p.out_z = d[2];
      p.out_w = d[3];
      return p;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic [31:0] encode_op(input logic [4:0] op);
      logic [31:0] w;
      w = $urandom;
      case (op)
         OP_LL:     w[31:26] = 6'h30;
         OP_SC:     w[31:26] = 6'h38;
         OP_LVLQ:   begin w[31:26] = 6'h35; w[1] = 1'b0; end
         OP_LVRQ:   begin w[31:26] = 6'h35; w[1] = 1'b1; end
         OP_SVLQ:   begin w[31:26] = 6'h3D; w[1] = 1'b0; end
         OP_SVRQ:   begin w[31:26] = 6'h3D; w[1] = 1'b1; end
         OP_VSBN:   begin w[31:26] = 6'h18; w[25:23] = 3'd2; end
         OP_VDET:   begin w[31:26] = 6'h19; w[25:23] = 3'd6; end
         OP_VWBN:   begin w[31:26] = 6'h34; w[25:24] = 2'b11; end
         OP_VRNDS:  w[31:16] = {6'h34, 5'd1, 5'd0};
         OP_VSBZ:   w[31:16] = {6'h34, 5'd1, 5'd22};
         OP_VLGB:   w[31:16] = {6'h34, 5'd1, 5'd23};
         OP_VI2C:   w[31:16] = {6'h34, 5'd1, 5'd29};
         OP_VI2US:  w[31:16] = {6'h34, 5'd1, 5'd30};
         OP_VSRT1:  w[31:16] = {6'h34, 5'd2, 5'd0};
         OP_VSRT2:  w[31:16] = {6'h34, 5'd2, 5'd1};
         OP_VBFY2:  w[31:16] = {6'h34, 5'd2, 5'd3};
         OP_VSRT3:  w[31:16] = {6'h34, 5'd2, 5'd8};
         OP_VSRT4:  w[31:16] = {6'h34, 5'd2, 5'd9};
         OP_VMFVC:  w[31:16] = {6'h34, 5'd2, 5'd16};
         OP_VMTVC:  w[31:16] = {6'h34, 5'd2, 5'd17};
         OP_VT4444: w[31:16] = {6'h34, 5'd2, 5'd25};
         OP_VT5551: w[31:16] = {6'h34, 5'd2, 5'd26};
         default: ;
      endcase
      return w;
   endfunction

   // float-ish lane values that hit zeros, denormals, infinities and nans often
   function automatic logic [31:0] pick_lane();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[30:23] = 8'h00;
         1: v[30:23] = 8'hFF;
         2: v[30:0] = 31'd0;
         3: v[30:0] = 31'h7F80_0000;
         4: v[30:23] = 8'(127 + $urandom_range(0, 16) - 8);
         default: ;
      endcase
      return v;
   endfunction

   function automatic lane_req_type make_item(input logic [4:0] op);
      lane_req_type r;
      r.instr_word = encode_op(op);
      r.src_x = pick_lane();
      r.src_y = pick_lane();
      r.src_z = pick_lane();
      r.src_w = pick_lane();
      r.tgt_x = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 300) - 150);
      return r;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_idle > 0) begin
            send_idle <= send_idle - 1;
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_idle <= $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_send) begin
            {req_instr_word, req_src_x, req_src_y, req_src_z, req_src_w, req_tgt_x}
               <= pending_items[0];
            expected_lanes.push_back(predict_lanes(pending_items.pop_front()));
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      lane_rsp_type got;
      lane_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_idle <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_which_op, rsp_dest_reg, rsp_result_count,
                   rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w};
            if (expected_lanes.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $realtime, got);
               fail_count++;
            end else begin
               want = expected_lanes.pop_front();
               if (got.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           want.status, got.status);
               if (got.which_op !== want.which_op)
                  $display("%0t: which_op expected %0d actual %0d", $realtime,
                           want.which_op, got.which_op);
               if (got.dest_reg !== want.dest_reg)
                  $display("%0t: dest_reg expected %0d actual %0d", $realtime,
                           want.dest_reg, got.dest_reg);
               if (got.result_count !== want.result_count)
                  $display("%0t: result_count expected %0d actual %0d", $realtime,
                           want.result_count, got.result_count);
               if (got.out_x !== want.out_x)
                  $display("%0t: out_x expected %h actual %h", $realtime, want.out_x, got.out_x);
               if (got.out_y !== want.out_y)
                  $display("%0t: out_y expected %h actual %h", $realtime, want.out_y, got.out_y);
               if (got.out_z !== want.out_z)
                  $display("%0t: out_z expected %h actual %h", $realtime, want.out_z, got.out_z);
               if (got.out_w !== want.out_w)
                  $display("%0t: out_w expected %h actual %h", $realtime, want.out_w, got.out_w);
               if (got !== want) fail_count++;
            end
         end
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_idle <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      lane_req_type r;
      fail_count = 0;
      cycle_count = 0;
      quiet_tail = 1'b0;
      hold_send = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      {req_instr_word, req_src_x, req_src_y, req_src_z, req_src_w, req_tgt_x} = '0;

      // directed: every op once, then field extremes and sort corner cases
      for (int op = 0; op <= 23; op++) pending_items.push_back(make_item(5'(op)));
      pending_items.push_back('0);
      pending_items.push_back('1);
      r = make_item(OP_VSRT1);
      r.instr_word[15] = 1'b1;
      r.instr_word[7] = 1'b1;
      // -0 against +0 and nan against a number
      {r.src_x, r.src_y, r.src_z, r.src_w} = {32'h8000_0000, 32'h0, 32'h7FC0_0000, 32'h3F80_0000};
      pending_items.push_back(r);
      r.instr_word = encode_op(OP_VSRT2);
      r.instr_word[15] = 1'b1;
      r.instr_word[7] = 1'b1;
      {r.src_x, r.src_y, r.src_z, r.src_w} = {32'hFFC0_0000, 32'h7F80_0001, 32'h0, 32'h8000_0000};
      pending_items.push_back(r);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < 1850; n++) begin
         if (n == 900) begin
            // let everything drain before carrying on
            wait (pending_items.size() == 0);
            hold_send = 1'b1;
            wait (expected_lanes.size() == 0);
            @(posedge clock);
            hold_send = 1'b0;
         end
         if (n == 1600) quiet_tail = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end else begin
            r = make_item(5'($urandom_range(OP_LL, OP_VT5551)));
         end
         pending_items.push_back(r);
         if (pending_items.size() > 16) wait (pending_items.size() < 8);
      end

      wait (pending_items.size() == 0 && expected_lanes.size() == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_lanes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/velu_pkg.sv
design/vector_extra_lane_unit_top.sv
tb/tb_vector_extra_lane_unit_top.sv
